FILE: hdl/dggp_pkg.sv
// Shared types and constants of the depth-to-ground-grid projection block.
// Used by the channel interfaces and by every module under hdl/.
package dggp_pkg;

  // Size limits of the block.
  localparam int MAX_GRID_DIM  = 4096;
  localparam int MAX_IMAGE_DIM = 1024;

  // Field widths.
  localparam int PIX_W    = 10;
  localparam int DEPTH_W  = 16;
  localparam int CELL_W   = 12;
  localparam int INV_W    = 24;
  localparam int CTR_W    = 16;
  localparam int CPM_W    = 10;
  localparam int GSIZE_W  = 13;
  localparam int CFG_W    = 24;
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);

  // Center registers carry six fraction bits.
  localparam int CTR_FRAC = 6;

  // Nearest accepted depth is max / NEAR_RATIO (0.05 of the maximum).
  localparam int NEAR_RATIO = 20;
  localparam int NEAR_W     = DEPTH_W + 5;

  // Arithmetic widths of one lane.
  localparam int MAG_W  = CTR_W;                 // |64*pix - ctr|
  localparam int M1_W   = MAG_W + DEPTH_W;       // mag * depth
  localparam int P_W    = M1_W + INV_W;          // mag * depth * inv
  localparam int P_FRAC = 30;
  localparam int U_W    = P_W - P_FRAC + CPM_W;  // floor(p * cpm / 2^30)

  // Division by 1000 in two reciprocal steps: the upper chunk, then the
  // remainder joined to the lower chunk. Each reciprocal is rounded up and
  // exact over its input range.
  localparam int DIV_K  = 1000;
  localparam int REM_W  = 10;
  localparam int LO_W   = 18;
  localparam int HI_W   = U_W - LO_W;
  localparam int M_HI_W = 19;
  localparam int S_HI   = HI_W + REM_W;
  localparam logic [M_HI_W-1:0] M_HI = M_HI_W'(268436);     // ceil(2^28 / 1000)
  localparam int QH_W   = 9;
  localparam int N_W    = REM_W + LO_W;
  localparam int M_LO_W = 29;
  localparam int S_LO   = N_W + REM_W;
  localparam logic [M_LO_W-1:0] M_LO = M_LO_W'(274877907);  // ceil(2^38 / 1000)
  localparam int Q_W    = QH_W + LO_W;
  localparam int S_W    = Q_W + 2;

  // Stages of the lane pipeline and depth of the front-to-back queue.
  localparam int LANE_STAGES = 7;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_FOCAL_X     = 3'd0,
    CFG_INV_FOCAL_Y     = 3'd1,
    CFG_CTR_COL         = 3'd2,
    CFG_CTR_ROW         = 3'd3,
    CFG_MAX_DISTANCE_MM = 3'd4,
    CFG_CELLS_PER_METRE = 3'd5,
    CFG_GRID_WIDTH      = 3'd6,
    CFG_GRID_HEIGHT     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [INV_W-1:0]   inv_focal_x;
    logic [INV_W-1:0]   inv_focal_y;
    logic [CTR_W-1:0]   ctr_col;
    logic [CTR_W-1:0]   ctr_row;
    logic [DEPTH_W-1:0] max_distance_mm;
    logic [CPM_W-1:0]   cells_per_metre;
    logic [GSIZE_W-1:0] grid_width;
    logic [GSIZE_W-1:0] grid_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    inv_focal_x:     INV_W'(65536),
    inv_focal_y:     INV_W'(65536),
    ctr_col:         CTR_W'(10240),
    ctr_row:         CTR_W'(7680),
    max_distance_mm: DEPTH_W'(3000),
    cells_per_metre: CPM_W'(100),
    grid_width:      GSIZE_W'(512),
    grid_height:     GSIZE_W'(512)
  };

  // Signed lateral offset of one axis, as sign and magnitude.
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } axis_t;

  // Classified pixel, handed from the front to the back.
  typedef struct packed {
    axis_t              ax_x;
    axis_t              ax_y;
    logic [DEPTH_W-1:0] depth;
    logic               in_range;
  } item_t;

  // Placement of one axis.
  typedef struct packed {
    logic [CELL_W-1:0] pos;
    logic              in_grid;
  } lane_res_t;

endpackage

FILE: hdl/dggp_if.sv
// Valid/ready channel interfaces for the pixel input and the cell result.
// Depends on dggp_pkg for the field widths.
interface dggp_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [dggp_pkg::PIX_W-1:0]   pixel_x;
  logic [dggp_pkg::PIX_W-1:0]   pixel_y;
  logic [dggp_pkg::DEPTH_W-1:0] depth_mm;
  logic                         depth_valid;

  modport source (output valid, pixel_x, pixel_y, depth_mm, depth_valid, input ready);
  modport sink   (input valid, pixel_x, pixel_y, depth_mm, depth_valid, output ready);
endinterface

interface dggp_cell_if;
  logic                         valid;
  logic                         ready;
  logic [dggp_pkg::CELL_W-1:0]  cell_x;
  logic [dggp_pkg::CELL_W-1:0]  cell_y;
  logic [dggp_pkg::DEPTH_W-1:0] cell_depth_mm;
  logic                         hit;

  modport source (output valid, cell_x, cell_y, cell_depth_mm, hit, input ready);
  modport sink   (input valid, cell_x, cell_y, cell_depth_mm, hit, output ready);
endinterface

FILE: hdl/dggp_front.sv
// Front end: accepts pixel beats, range-checks them and forms signed offsets.
// Depends on dggp_pkg and dggp_pixel_if.
module dggp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dggp_pkg::cfg_t       cfg_i,
  dggp_pixel_if.sink           pix_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output dggp_pkg::item_t      item_o
);

  logic            valid_q;
  dggp_pkg::item_t item_q;
  dggp_pkg::item_t item_d;
  logic            take;

  function automatic dggp_pkg::axis_t offset(input logic [dggp_pkg::PIX_W-1:0] px,
                                             input logic [dggp_pkg::CTR_W-1:0] ctr);
    logic [dggp_pkg::CTR_W-1:0] p64;
    dggp_pkg::axis_t            a;
    p64   = dggp_pkg::CTR_W'(px) << dggp_pkg::CTR_FRAC;
    a.neg = p64 < ctr;
    a.mag = a.neg ? (ctr - p64) : (p64 - ctr);
    return a;
  endfunction

  logic [dggp_pkg::NEAR_W-1:0] near_scaled;

  always_comb begin
    near_scaled    = dggp_pkg::NEAR_W'(pix_i.depth_mm) * dggp_pkg::NEAR_W'(dggp_pkg::NEAR_RATIO);
    item_d.ax_x    = offset(pix_i.pixel_x, cfg_i.ctr_col);
    item_d.ax_y    = offset(pix_i.pixel_y, cfg_i.ctr_row);
    item_d.depth   = pix_i.depth_mm;
    item_d.in_range = pix_i.depth_valid
        && (32'(pix_i.pixel_x) < 32'(dggp_pkg::MAX_IMAGE_DIM))
        && (32'(pix_i.pixel_y) < 32'(dggp_pkg::MAX_IMAGE_DIM))
        && (pix_i.depth_mm <= cfg_i.max_distance_mm)
        && (near_scaled >= dggp_pkg::NEAR_W'(cfg_i.max_distance_mm));
  end

  // Take a new beat whenever the holding register is empty or drains.
  assign take        = !valid_q || ready_i;
  assign pix_i.ready = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && pix_i.valid) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: hdl/dggp_queue.sv
// Short queue between front and back end of the projection block.
// Depends on dggp_pkg.
module dggp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dggp_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dggp_pkg::item_t out_item_o
);

  localparam int PTR_W = $clog2(dggp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(dggp_pkg::QUEUE_DEPTH + 1);

  dggp_pkg::item_t   slot_q [dggp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              push, pop;

  assign in_ready_o  = count_q != CNT_W'(dggp_pkg::QUEUE_DEPTH);
  assign out_valid_o = count_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_ready_i && out_valid_o;
  assign out_item_o  = slot_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (32'(p) == dggp_pkg::QUEUE_DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= advance(wr_ptr_q);
      if (pop)  rd_ptr_q <= advance(rd_ptr_q);
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

FILE: hdl/dggp_lane.sv
// One axis of the back end: scale the offset by depth, focal reciprocal and
// grid resolution, divide by 1000 and place the result on the grid.
// Depends on dggp_pkg.
module dggp_lane (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  dggp_pkg::axis_t                ax_i,
  input  logic [dggp_pkg::DEPTH_W-1:0]   depth_i,
  input  logic [dggp_pkg::INV_W-1:0]     inv_i,
  input  logic [dggp_pkg::CPM_W-1:0]     cpm_i,
  input  logic [dggp_pkg::GSIZE_W-1:0]   size_i,
  output dggp_pkg::lane_res_t            res_o
);

  localparam int LAST = dggp_pkg::LANE_STAGES - 1;
  localparam int AW   = dggp_pkg::U_W - dggp_pkg::CPM_W + dggp_pkg::CPM_W;
  localparam int BW   = dggp_pkg::P_FRAC + dggp_pkg::CPM_W;
  localparam int PH_W = dggp_pkg::HI_W + dggp_pkg::M_HI_W;
  localparam int PL_W = dggp_pkg::N_W + dggp_pkg::M_LO_W;

  logic [LAST-1:0]                neg_q;
  logic [dggp_pkg::M1_W-1:0]      m1_q;
  logic [dggp_pkg::P_W-1:0]       p_q;
  logic [dggp_pkg::U_W-1:0]       u_q;
  logic [dggp_pkg::HI_W-1:0]      hi_q;
  logic [dggp_pkg::LO_W-1:0]      lo_q;
  logic [dggp_pkg::QH_W-1:0]      qh4_q, qh5_q;
  logic [dggp_pkg::N_W-1:0]       n_q;
  logic [dggp_pkg::Q_W-1:0]       q_q;
  dggp_pkg::lane_res_t            res_q;

  logic [AW-1:0]                  a_prod;
  logic [BW-1:0]                  b_prod;
  logic [PH_W-1:0]                hi_prod;
  logic [dggp_pkg::HI_W-1:0]      hi_rem;
  logic [PL_W-1:0]                lo_prod;
  logic [dggp_pkg::GSIZE_W-1:0]   w_eff;
  logic signed [dggp_pkg::S_W-1:0] s_raw, s_adj;
  dggp_pkg::lane_res_t            res_d;

  always_comb begin
    a_prod  = AW'(p_q[dggp_pkg::P_W-1:dggp_pkg::P_FRAC]) * AW'(cpm_i);
    b_prod  = BW'(p_q[dggp_pkg::P_FRAC-1:0]) * BW'(cpm_i);
    hi_prod = PH_W'(u_q[dggp_pkg::U_W-1:dggp_pkg::LO_W]) * PH_W'(dggp_pkg::M_HI);
    hi_rem  = hi_q - dggp_pkg::HI_W'(qh4_q) * dggp_pkg::HI_W'(dggp_pkg::DIV_K);
    lo_prod = PL_W'(n_q) * PL_W'(dggp_pkg::M_LO);
  end

  // Half-grid shift: odd sizes add half a cell, truncated toward zero.
  always_comb begin
    w_eff = (32'(size_i) > dggp_pkg::MAX_GRID_DIM)
          ? dggp_pkg::GSIZE_W'(dggp_pkg::MAX_GRID_DIM) : size_i;
    s_raw = neg_q[LAST-1]
          ? dggp_pkg::S_W'(w_eff >> 1) - dggp_pkg::S_W'(q_q)
          : dggp_pkg::S_W'(w_eff >> 1) + dggp_pkg::S_W'(q_q);
    s_adj = (w_eff[0] && s_raw < 0) ? s_raw + dggp_pkg::S_W'(1) : s_raw;
    res_d.in_grid = (s_adj >= 0) && (s_adj < dggp_pkg::S_W'(w_eff));
    res_d.pos     = s_adj[dggp_pkg::CELL_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= {neg_q[LAST-2:0], ax_i.neg};
      m1_q  <= dggp_pkg::M1_W'(ax_i.mag) * dggp_pkg::M1_W'(depth_i);
      p_q   <= dggp_pkg::P_W'(m1_q) * dggp_pkg::P_W'(inv_i);
      u_q   <= dggp_pkg::U_W'(a_prod) + dggp_pkg::U_W'(b_prod[BW-1:dggp_pkg::P_FRAC]);
      hi_q  <= u_q[dggp_pkg::U_W-1:dggp_pkg::LO_W];
      lo_q  <= u_q[dggp_pkg::LO_W-1:0];
      qh4_q <= hi_prod[dggp_pkg::S_HI +: dggp_pkg::QH_W];
      n_q   <= {hi_rem[dggp_pkg::REM_W-1:0], lo_q};
      qh5_q <= qh4_q;
      q_q   <= {qh5_q, lo_prod[dggp_pkg::S_LO +: dggp_pkg::LO_W]};
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: hdl/dggp_back.sv
// Back end: two projection lanes under one stall enable, with the valid,
// range flag and depth carried alongside; the last stage is the output register.
// Depends on dggp_pkg, dggp_cell_if and dggp_lane.
module dggp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dggp_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  input  dggp_pkg::item_t item_i,
  output logic            ready_o,
  dggp_cell_if.source     cell_o
);

  localparam int LAST = dggp_pkg::LANE_STAGES - 1;

  logic [LAST:0]                vld_q;
  logic [LAST:0]                ok_q;
  logic [dggp_pkg::DEPTH_W-1:0] depth_q [dggp_pkg::LANE_STAGES];
  logic                         en;
  dggp_pkg::lane_res_t          res_x, res_y;
  logic                         hit;

  // Advance the whole pipe unless a finished beat is held at the output.
  assign en      = !vld_q[LAST] || cell_o.ready;
  assign ready_o = en;

  dggp_lane u_lane_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .ax_i    (item_i.ax_x),
    .depth_i (item_i.depth),
    .inv_i   (cfg_i.inv_focal_x),
    .cpm_i   (cfg_i.cells_per_metre),
    .size_i  (cfg_i.grid_width),
    .res_o   (res_x)
  );

  dggp_lane u_lane_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .ax_i    (item_i.ax_y),
    .depth_i (item_i.depth),
    .inv_i   (cfg_i.inv_focal_y),
    .cpm_i   (cfg_i.cells_per_metre),
    .size_i  (cfg_i.grid_height),
    .res_o   (res_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q       <= {ok_q[LAST-1:0], item_i.in_range};
      depth_q[0] <= item_i.depth;
      for (int i = 1; i < dggp_pkg::LANE_STAGES; i++) begin
        depth_q[i] <= depth_q[i-1];
      end
    end
  end

  assign hit                  = ok_q[LAST] && res_x.in_grid && res_y.in_grid;
  assign cell_o.valid         = vld_q[LAST];
  assign cell_o.hit           = hit;
  assign cell_o.cell_x        = hit ? res_x.pos : '0;
  assign cell_o.cell_y        = hit ? res_y.pos : '0;
  assign cell_o.cell_depth_mm = hit ? depth_q[LAST] : '0;

endmodule

FILE: hdl/depth_to_ground_grid_projection.sv
// Depth pixel to top-down grid cell projection, top level.
// Throughput: one pixel per cycle while the output is not stalled; the seven-stage lane
// pipeline takes a beat on every clock in which it is enabled.
// Reset: rst_ni clears all valid state and loads the configuration defaults.
// Depends on dggp_pkg, dggp_if, dggp_front, dggp_queue and dggp_back.
module depth_to_ground_grid_projection (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  dggp_pixel_if.sink                        pix_i,
  dggp_cell_if.source                       cell_o,
  input  logic                              cfg_we_i,
  input  logic [dggp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dggp_pkg::CFG_W-1:0]        cfg_wdata_i
);

  // Configuration registers. The user must change them only while the block is idle;
  // the block does not enforce this. Every stage reads them directly, with no per-beat copy.
  dggp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= dggp_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (dggp_pkg::cfg_idx_e'(cfg_idx_i))
        dggp_pkg::CFG_INV_FOCAL_X: begin
          cfg_q.inv_focal_x <= cfg_wdata_i[dggp_pkg::INV_W-1:0];
        end
        dggp_pkg::CFG_INV_FOCAL_Y: begin
          cfg_q.inv_focal_y <= cfg_wdata_i[dggp_pkg::INV_W-1:0];
        end
        dggp_pkg::CFG_CTR_COL: begin
          cfg_q.ctr_col <= cfg_wdata_i[dggp_pkg::CTR_W-1:0];
        end
        dggp_pkg::CFG_CTR_ROW: begin
          cfg_q.ctr_row <= cfg_wdata_i[dggp_pkg::CTR_W-1:0];
        end
        dggp_pkg::CFG_MAX_DISTANCE_MM: begin
          cfg_q.max_distance_mm <= cfg_wdata_i[dggp_pkg::DEPTH_W-1:0];
        end
        dggp_pkg::CFG_CELLS_PER_METRE: begin
          cfg_q.cells_per_metre <= cfg_wdata_i[dggp_pkg::CPM_W-1:0];
        end
        dggp_pkg::CFG_GRID_WIDTH: begin
          cfg_q.grid_width <= cfg_wdata_i[dggp_pkg::GSIZE_W-1:0];
        end
        dggp_pkg::CFG_GRID_HEIGHT: begin
          cfg_q.grid_height <= cfg_wdata_i[dggp_pkg::GSIZE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front end: classify each pixel (depth window, valid flag, image bounds)
  // and form the signed offset from the optical center on both axes.
  logic            front_valid;
  logic            queue_ready;
  dggp_pkg::item_t front_item;

  dggp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .pix_i   (pix_i),
    .valid_o (front_valid),
    .ready_i (queue_ready),
    .item_o  (front_item)
  );

  // Two-entry queue: lets the front keep taking beats after the back end stalls,
  // until the queue is full, and keeps the ready paths short.
  logic            queue_valid;
  logic            back_ready;
  dggp_pkg::item_t queue_item;

  dggp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (queue_ready),
    .in_item_i   (front_item),
    .out_valid_o (queue_valid),
    .out_ready_i (back_ready),
    .out_item_o  (queue_item)
  );

  // Back end: multiply through depth, focal reciprocal and resolution,
  // divide by 1000, shift by half the grid and drive the cell beat.
  dggp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (queue_valid),
    .item_i  (queue_item),
    .ready_o (back_ready),
    .cell_o  (cell_o)
  );

  // A rejected pixel leaves every result field at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_o.valid && !cell_o.hit |->
      cell_o.cell_x == '0 && cell_o.cell_y == '0 && cell_o.cell_depth_mm == '0)
    else $error("rejected beat carries nonzero fields");

  // No beat can reach the output in the first cycle after reset.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !cell_o.valid)
    else $error("output valid right after reset");

  // A full queue must hold at least one beat for the back end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !queue_ready |-> queue_valid)
    else $error("queue reports full while empty");

  // While the output beat is held, the back end must not drain the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_o.valid && !cell_o.ready |-> !(queue_valid && back_ready))
    else $error("queue drained during output stall");

endmodule
